### rtl/dpq_pkg.sv
// Shared types and codes for the deduplicating position queue.
package dpq_pkg;

  localparam int unsigned PosW    = 16;
  localparam int unsigned CmdW    = 2;
  localparam int unsigned StatusW = 3;
  localparam int unsigned CountW  = 4;

  typedef enum logic [CmdW-1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_POP    = 2'd2
  } cmd_t;

  typedef enum logic [StatusW-1:0] {
    ST_DONE     = 3'd0,
    ST_DUP      = 3'd1,
    ST_FULL     = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_EMPTY    = 3'd4
  } status_t;

  // Per-beat control broadcast to every cell.
  typedef struct packed {
    logic add_go;     // append accepted: tail cell loads position
    logic remove_cmd; // remove command: cells at or past a hit shift
    logic pop_go;     // pop of a non-empty queue: all cells shift
  } cell_ctrl_t;

endpackage

### rtl/dpq_cell.sv
// One queue slot: holds an entry, compares it, shifts toward the head.
module dpq_cell
  import dpq_pkg::*;
#(
  parameter int unsigned IDX = 0,
  parameter int unsigned CW  = 4
) (
  input  logic            clk,
  input  logic            load,         // beat accepted this cycle
  input  cell_ctrl_t      ctrl,
  input  logic [PosW-1:0] position,
  input  logic [CW-1:0]   count,
  input  logic            match_in,     // hit somewhere closer to the head
  input  logic [PosW-1:0] right_entry,  // entry of the neighbor toward the tail
  output logic            match_out,
  output logic [PosW-1:0] entry,
  output logic [PosW-1:0] entry_next
);

  logic occupied;
  logic hit;
  logic shift;
  logic write_tail;

  assign occupied   = CW'(IDX) < count;
  assign hit        = occupied && (entry == position);
  assign match_out  = match_in | hit;
  assign shift      = ctrl.pop_go | (ctrl.remove_cmd & match_out);
  assign write_tail = ctrl.add_go && (count == CW'(IDX));

  always_comb begin
    if (write_tail) begin
      entry_next = position;
    end else if (shift) begin
      entry_next = right_entry;
    end else begin
      entry_next = entry;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      entry <= entry_next;
    end
  end

endmodule

### rtl/dedup_position_queue.sv
// Top level: deduplicating position queue built as a row of compare/shift cells.
// The result beat for an accepted input beat is registered and presented in the next cycle.
// Throughput: one beat per cycle while the output is not stalled; match, compaction
//   and tail write all resolve in the cell row within the accepting cycle.
// Reset (rst, synchronous): empties the queue and drops any pending result;
//   slot contents are not cleared, only the fill count.
module dedup_position_queue
  import dpq_pkg::*;
#(
  parameter int unsigned DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [1:0] command, [17:2] position, [23:18] zero
  input  logic [23:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [2:0] status, [3] head_valid, [19:4] head_position, [23:20] count
  output logic [23:0] m_axis_tdata
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  // Input beat fields.
  logic [CmdW-1:0] command;
  logic [PosW-1:0] position;
  logic            load;

  // Queue state.
  logic [CW-1:0]   count;
  logic [CW-1:0]   count_next;
  status_t         status;
  cell_ctrl_t      ctrl;
  logic            any_match;
  logic            full;

  // Cell row wiring; match chain runs head to tail.
  logic [PosW-1:0] entries      [DEPTH];
  logic [PosW-1:0] entries_next [DEPTH];
  logic [DEPTH:0]  match_chain;

  // Result register.
  logic            out_valid;
  status_t         out_status;
  logic            out_head_valid;
  logic [PosW-1:0] out_head_position;
  logic [CountW-1:0] out_count;
  logic [CW+CountW-1:0] count_ext;

  assign command  = s_axis_tdata[CmdW-1:0];
  assign position = s_axis_tdata[CmdW+PosW-1:CmdW];

  // Result register doubles as the skid: take a beat whenever it frees up.
  assign s_axis_tready = !out_valid || m_axis_tready;
  assign load          = s_axis_tvalid && s_axis_tready;

  assign any_match = match_chain[DEPTH];
  assign full      = count >= CW'(DEPTH);

  // Command decode: duplicate check wins over full on an add.
  always_comb begin
    status      = ST_DONE;
    count_next  = count;
    ctrl        = '0;
    unique case (command)
      CMD_ADD: begin
        if (any_match) begin
          status = ST_DUP;
        end else if (full) begin
          status = ST_FULL;
        end else begin
          ctrl.add_go = 1'b1;
          count_next  = count + CW'(1);
        end
      end
      CMD_REMOVE: begin
        ctrl.remove_cmd = 1'b1;
        if (any_match) begin
          count_next = count - CW'(1);
        end else begin
          status = ST_NOTFOUND;
        end
      end
      CMD_POP: begin
        if (count == '0) begin
          status = ST_EMPTY;
        end else begin
          ctrl.pop_go = 1'b1;
          count_next  = count - CW'(1);
        end
      end
      default: begin
        // unused code: no change, status done
        status = ST_DONE;
      end
    endcase
  end

  assign match_chain[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [PosW-1:0] right_entry;
    if (i == DEPTH - 1) begin : g_last
      assign right_entry = entries[i];
    end else begin : g_mid
      assign right_entry = entries[i+1];
    end

    dpq_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk         (clk),
      .load        (load),
      .ctrl        (ctrl),
      .position    (position),
      .count       (count),
      .match_in    (match_chain[i]),
      .right_entry (right_entry),
      .match_out   (match_chain[i+1]),
      .entry       (entries[i]),
      .entry_next  (entries_next[i])
    );
  end

  // Count field carries only the low bits of the fill count.
  assign count_ext = {{CountW{1'b0}}, count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_status        <= status;
      out_head_valid    <= count_next != '0;
      out_head_position <= (count_next != '0) ? entries_next[0] : '0;
      out_count         <= count_ext[CountW-1:0];
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_count, out_head_position, out_head_valid, out_status};

endmodule
